// ----- rtl/pss_pkg.sv -----
// Package for the periodic stream scheduler: item types, op and status codes.
// No dependencies.
package pss_pkg;

	localparam int unsigned MAX_ID = 15;
	localparam logic [7:0] PENDING_MAX = 8'd255;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0, OP_REMOVE = 3'd1, OP_QUERY = 3'd2, OP_LIST = 3'd3,
		OP_TICK = 3'd4, OP_POLL = 3'd5, OP_STOP = 3'd6, OP_NONE = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0, ST_UNKNOWN = 4'd1, ST_NOT_STREAMABLE = 4'd2, ST_ID_ZERO = 4'd3,
		ST_ID_INVALID = 4'd4, ST_IN_USE = 4'd5, ST_FULL = 4'd6, ST_MISMATCH = 4'd7,
		ST_NOT_FOUND = 4'd8
	} status_t;

	localparam logic CFG_STREAMABLE = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  sid;
		logic [15:0] period;
		logic [3:0]  command_index;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [15:0] active_mask;
		logic [15:0] found_period;
		logic [3:0]  found_command;
		logic        fired;
		logic [3:0]  fired_stream;
		logic [3:0]  fired_command;
	} rsp_t;

endpackage

// ----- rtl/periodic_stream_scheduler_top.sv -----
// Periodic stream scheduler top level: table, sequencer and config registers.
// Depends on pss_pkg.
//
//  channel | signals                          | accepted when
//  req     | start, busy, req                 | start && !busy
//  rsp     | done, rsp                        | done (one cycle, no stall)
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// Each item walks the table one entry per cycle through a single entry
// unit, for every op (add finds the sync countdown and the free slot in
// the same pass). Result is shown for one cycle with done.
// Reset clears every table field in flip-flops at once.
// The receiver cannot stall; busy is high from accept until the done cycle.
module periodic_stream_scheduler_top #(
	parameter int TABLE_DEPTH = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pss_pkg::req_t    req,
	output logic             done,
	output pss_pkg::rsp_t    rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [15:0]      cfg_data
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001, S_WALK = 3'b010, S_FIN = 3'b100
	} state_t;

	state_t state_q;
	logic [IW-1:0] idx_q;
	pss_pkg::req_t req_q;
	logic [15:0] mask_q;
	logic [4:0]  count_q;

	logic [3:0]  id_q [TABLE_DEPTH];
	logic [3:0]  cmd_q [TABLE_DEPTH];
	logic [15:0] per_q [TABLE_DEPTH];
	logic [15:0] cd_q [TABLE_DEPTH];
	logic [7:0]  pend_q [TABLE_DEPTH];

	// walk accumulators
	logic          hit_q, free_q, fired_q;
	logic [IW-1:0] hit_idx_q, free_idx_q, fire_idx_q;
	logic [15:0]   sync_cd_q, acc_mask_q;
	logic [15:0]   per_eff;

	logic [3:0]  e_id;
	logic [15:0] e_per, e_cd, cd_dec;
	logic [7:0]  e_pend;
	logic        e_act, e_match;

	pss_pkg::rsp_t rsp_d;

	assign per_eff = (req_q.period == 16'd0) ? 16'd1 : req_q.period;
	assign e_id = id_q[idx_q];
	assign e_per = per_q[idx_q];
	assign e_cd = cd_q[idx_q];
	assign e_pend = pend_q[idx_q];
	assign e_act = e_id != 4'd0;
	assign e_match = e_act && ({4'd0, e_id} == req_q.sid);
	assign cd_dec = e_cd - 16'd1;

	assign busy = state_q != S_IDLE;
	assign cfg_ready = !busy;

	// early status (independent of table): id zero for any op, plus the add checks
	logic [3:0] pre_st;
	always_comb begin
		pre_st = pss_pkg::ST_OK;
		if (req_q.sid == 8'd0) pre_st = pss_pkg::ST_ID_ZERO;
		if (req_q.command == pss_pkg::OP_ADD) begin
			if ({1'b0, req_q.command_index} >= count_q) pre_st = pss_pkg::ST_UNKNOWN;
			else if (!mask_q[req_q.command_index]) pre_st = pss_pkg::ST_NOT_STREAMABLE;
			else if (req_q.sid == 8'd0) pre_st = pss_pkg::ST_ID_ZERO;
			else if (req_q.sid > 8'(pss_pkg::MAX_ID)) pre_st = pss_pkg::ST_ID_INVALID;
		end
	end

	always_comb begin
		rsp_d = '0;
		case (req_q.command)
			pss_pkg::OP_ADD: begin
				if (pre_st != pss_pkg::ST_OK) rsp_d.status = pre_st;
				else if (hit_q) rsp_d.status = pss_pkg::ST_IN_USE;
				else if (!free_q) rsp_d.status = pss_pkg::ST_FULL;
			end
			pss_pkg::OP_REMOVE: begin
				if (pre_st != pss_pkg::ST_OK) rsp_d.status = pre_st;
				else if (!hit_q) rsp_d.status = pss_pkg::ST_NOT_FOUND;
				else if (cmd_q[hit_idx_q] != req_q.command_index)
					rsp_d.status = pss_pkg::ST_MISMATCH;
			end
			pss_pkg::OP_QUERY: begin
				if (pre_st != pss_pkg::ST_OK) rsp_d.status = pre_st;
				else if (!hit_q) rsp_d.status = pss_pkg::ST_NOT_FOUND;
				else begin
					rsp_d.found_period = per_q[hit_idx_q];
					rsp_d.found_command = cmd_q[hit_idx_q];
				end
			end
			pss_pkg::OP_LIST: rsp_d.active_mask = acc_mask_q;
			pss_pkg::OP_POLL: begin
				if (fired_q) begin
					rsp_d.fired = 1'b1;
					rsp_d.fired_stream = id_q[fire_idx_q];
					rsp_d.fired_command = cmd_q[fire_idx_q];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
			rsp <= '0;
			req_q <= '0;
			mask_q <= 16'h0108;
			count_q <= 5'd9;
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			fired_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
			fire_idx_q <= '0;
			sync_cd_q <= 16'd0;
			acc_mask_q <= 16'd0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				id_q[i] <= 4'd0;
				cmd_q[i] <= 4'd0;
				per_q[i] <= 16'd0;
				cd_q[i] <= 16'd0;
				pend_q[i] <= 8'd0;
			end
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == pss_pkg::CFG_STREAMABLE) mask_q <= cfg_data;
						else count_q <= cfg_data[4:0];
					end
					if (start) begin
						req_q <= req;
						idx_q <= '0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						fired_q <= 1'b0;
						acc_mask_q <= 16'd0;
						hit_idx_q <= '0;
						free_idx_q <= '0;
						fire_idx_q <= '0;
						sync_cd_q <= (req.period == 16'd0) ? 16'd1 : req.period;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (e_match && !hit_q) begin
						hit_q <= 1'b1;
						hit_idx_q <= idx_q;
					end
					if (!e_act && !free_q) begin
						free_q <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (e_act && e_per == per_eff) sync_cd_q <= e_cd;
					if (e_act) acc_mask_q[e_id] <= 1'b1;
					case (req_q.command)
						pss_pkg::OP_TICK: begin
							if (e_act) begin
								if (cd_dec == 16'd0) begin
									cd_q[idx_q] <= e_per;
									if (e_pend != pss_pkg::PENDING_MAX)
										pend_q[idx_q] <= e_pend + 8'd1;
								end else cd_q[idx_q] <= cd_dec;
							end
						end
						pss_pkg::OP_POLL: begin
							if (!fired_q && e_act && e_pend != 8'd0) begin
								fired_q <= 1'b1;
								fire_idx_q <= idx_q;
								pend_q[idx_q] <= e_pend - 8'd1;
							end
						end
						pss_pkg::OP_STOP: id_q[idx_q] <= 4'd0;
						default: ;
					endcase
					if (idx_q == LAST) state_q <= S_FIN;
					else idx_q <= idx_q + 1'b1;
				end
				S_FIN: begin
					rsp <= rsp_d;
					case (req_q.command)
						pss_pkg::OP_ADD: begin
							if (rsp_d.status == pss_pkg::ST_OK) begin
								id_q[free_idx_q] <= req_q.sid[3:0];
								cmd_q[free_idx_q] <= req_q.command_index;
								per_q[free_idx_q] <= per_eff;
								cd_q[free_idx_q] <= sync_cd_q;
								pend_q[free_idx_q] <= 8'd0;
							end
						end
						pss_pkg::OP_REMOVE: begin
							if (rsp_d.status == pss_pkg::ST_OK) id_q[hit_idx_q] <= 4'd0;
						end
						default: ;
					endcase
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && idx_q == LAST) |=> state_q == S_FIN)
		else $error("walk overrun");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for periodic_stream_scheduler_top: a directed table
// then random ops, each result compared with a built-in table predictor.
// Depends on pss_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int DEPTH = 12;
	localparam int N_RANDOM = 1250;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	pss_pkg::req_t req = '0;
	logic done;
	pss_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	periodic_stream_scheduler_top #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [15:0] streamable;
	logic [4:0]  cmd_count;
	logic [3:0]  t_id [DEPTH];
	logic [3:0]  t_cmd [DEPTH];
	logic [15:0] t_per [DEPTH];
	logic [15:0] t_cd [DEPTH];
	logic [7:0]  t_pend [DEPTH];

	pss_pkg::rsp_t expected_rsp [$];
	int errors = 0;
	int cycles = 0;

	function automatic pss_pkg::rsp_t schedule_op(pss_pkg::req_t r);
		pss_pkg::rsp_t o;
		logic [15:0] per, cd;
		int slot, e;
		o = '0;
		e = -1;
		if (r.sid != 0 && r.sid <= pss_pkg::MAX_ID)
			for (int i = 0; i < DEPTH; i++)
				if (e < 0 && t_id[i] == r.sid[3:0]) e = i;
		case (pss_pkg::op_t'(r.command))
			pss_pkg::OP_ADD: begin
				if (r.command_index >= cmd_count) o.status = pss_pkg::ST_UNKNOWN;
				else if (!streamable[r.command_index]) o.status = pss_pkg::ST_NOT_STREAMABLE;
				else if (r.sid == 0) o.status = pss_pkg::ST_ID_ZERO;
				else if (r.sid > pss_pkg::MAX_ID) o.status = pss_pkg::ST_ID_INVALID;
				else if (e >= 0) o.status = pss_pkg::ST_IN_USE;
				else begin
					per = (r.period == 0) ? 16'd1 : r.period;
					cd = per;
					slot = -1;
					for (int i = 0; i < DEPTH; i++) begin
						if (t_id[i] != 0 && t_per[i] == per) cd = t_cd[i];
						if (slot < 0 && t_id[i] == 0) slot = i;
					end
					if (slot < 0) o.status = pss_pkg::ST_FULL;
					else begin
						t_id[slot] = r.sid[3:0];
						t_cmd[slot] = r.command_index;
						t_per[slot] = per;
						t_cd[slot] = cd;
						t_pend[slot] = 0;
					end
				end
			end
			pss_pkg::OP_REMOVE: begin
				if (r.sid == 0) o.status = pss_pkg::ST_ID_ZERO;
				else if (e < 0) o.status = pss_pkg::ST_NOT_FOUND;
				else if (t_cmd[e] != r.command_index) o.status = pss_pkg::ST_MISMATCH;
				else t_id[e] = 0;
			end
			pss_pkg::OP_QUERY: begin
				if (r.sid == 0) o.status = pss_pkg::ST_ID_ZERO;
				else if (e < 0) o.status = pss_pkg::ST_NOT_FOUND;
				else begin
					o.found_period = t_per[e];
					o.found_command = t_cmd[e];
				end
			end
			pss_pkg::OP_LIST:
				for (int i = 0; i < DEPTH; i++)
					if (t_id[i] != 0) o.active_mask[t_id[i]] = 1'b1;
			pss_pkg::OP_TICK:
				for (int i = 0; i < DEPTH; i++)
					if (t_id[i] != 0) begin
						t_cd[i] = t_cd[i] - 16'd1;
						if (t_cd[i] == 0) begin
							if (t_pend[i] < pss_pkg::PENDING_MAX) t_pend[i] = t_pend[i] + 8'd1;
							t_cd[i] = t_per[i];
						end
					end
			pss_pkg::OP_POLL:
				for (int i = 0; i < DEPTH; i++)
					if (!o.fired && t_id[i] != 0 && t_pend[i] != 0) begin
						t_pend[i] = t_pend[i] - 8'd1;
						o.fired = 1'b1;
						o.fired_stream = t_id[i];
						o.fired_command = t_cmd[i];
					end
			pss_pkg::OP_STOP:
				for (int i = 0; i < DEPTH; i++) t_id[i] = 0;
			default: ;
		endcase
		return o;
	endfunction

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == pss_pkg::CFG_STREAMABLE) streamable = val;
		else cmd_count = val[4:0];
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// gap: idle cycles with the block ready before the item
	task automatic send_op(pss_pkg::req_t r, int gap);
		if (gap > 0) begin
			while (busy) @(posedge clk);
			repeat (gap - 1) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		expected_rsp.push_back(schedule_op(r));
		start <= 1'b0;
		@(posedge clk);
	endtask

	// response check
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				$error("result with none expected");
				errors++;
			end else begin
				pss_pkg::rsp_t x;
				x = expected_rsp.pop_front();
				if (rsp.status !== x.status) begin
					$error("status exp %0d got %0d", x.status, rsp.status); errors++;
				end
				if (rsp.active_mask !== x.active_mask) begin
					$error("active_mask exp %h got %h", x.active_mask, rsp.active_mask);
					errors++;
				end
				if (rsp.found_period !== x.found_period) begin
					$error("found_period exp %0d got %0d", x.found_period, rsp.found_period);
					errors++;
				end
				if (rsp.found_command !== x.found_command) begin
					$error("found_command exp %0d got %0d", x.found_command,
						rsp.found_command);
					errors++;
				end
				if (rsp.fired !== x.fired) begin
					$error("fired exp %0d got %0d", x.fired, rsp.fired); errors++;
				end
				if (rsp.fired_stream !== x.fired_stream) begin
					$error("fired_stream exp %0d got %0d", x.fired_stream, rsp.fired_stream);
					errors++;
				end
				if (rsp.fired_command !== x.fired_command) begin
					$error("fired_command exp %0d got %0d", x.fired_command,
						rsp.fired_command);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	typedef struct {
		pss_pkg::op_t op;
		logic [7:0]   id;
		logic [15:0]  per;
		logic [3:0]   ci;
		logic         chk;
		logic [3:0]   st;
	} row_t;

	row_t directed [] = '{
		'{pss_pkg::OP_LIST,   8'd0,   16'd0,    4'd0, 1'b1, pss_pkg::ST_OK},
		'{pss_pkg::OP_POLL,   8'd0,   16'd0,    4'd0, 1'b1, pss_pkg::ST_OK},
		'{pss_pkg::OP_ADD,    8'd1,   16'd1,    4'd9, 1'b1, pss_pkg::ST_UNKNOWN},
		'{pss_pkg::OP_ADD,    8'd1,   16'd1,    4'd0, 1'b1, pss_pkg::ST_NOT_STREAMABLE},
		'{pss_pkg::OP_ADD,    8'd0,   16'd1,    4'd3, 1'b1, pss_pkg::ST_ID_ZERO},
		'{pss_pkg::OP_ADD,    8'd16,  16'd1,    4'd3, 1'b1, pss_pkg::ST_ID_INVALID},
		'{pss_pkg::OP_ADD,    8'd255, 16'd1,    4'd8, 1'b1, pss_pkg::ST_ID_INVALID},
		'{pss_pkg::OP_ADD,    8'd1,   16'd0,    4'd3, 1'b1, pss_pkg::ST_OK},
		'{pss_pkg::OP_ADD,    8'd1,   16'd5,    4'd3, 1'b1, pss_pkg::ST_IN_USE},
		'{pss_pkg::OP_ADD,    8'd15,  16'hFFFF, 4'd8, 1'b1, pss_pkg::ST_OK},
		'{pss_pkg::OP_ADD,    8'd2,   16'd1,    4'd8, 1'b1, pss_pkg::ST_OK},
		'{pss_pkg::OP_QUERY,  8'd15,  16'd0,    4'd0, 1'b0, pss_pkg::ST_OK},
		'{pss_pkg::OP_QUERY,  8'd0,   16'd0,    4'd0, 1'b1, pss_pkg::ST_ID_ZERO},
		'{pss_pkg::OP_QUERY,  8'd200, 16'd0,    4'd0, 1'b1, pss_pkg::ST_NOT_FOUND},
		'{pss_pkg::OP_LIST,   8'd0,   16'd0,    4'd0, 1'b0, pss_pkg::ST_OK},
		'{pss_pkg::OP_TICK,   8'd0,   16'd0,    4'd0, 1'b0, pss_pkg::ST_OK},
		'{pss_pkg::OP_POLL,   8'd0,   16'd0,    4'd0, 1'b0, pss_pkg::ST_OK},
		'{pss_pkg::OP_POLL,   8'd0,   16'd0,    4'd0, 1'b0, pss_pkg::ST_OK},
		'{pss_pkg::OP_REMOVE, 8'd0,   16'd0,    4'd3, 1'b1, pss_pkg::ST_ID_ZERO},
		'{pss_pkg::OP_REMOVE, 8'd2,   16'd0,    4'd3, 1'b1, pss_pkg::ST_MISMATCH},
		'{pss_pkg::OP_REMOVE, 8'd99,  16'd0,    4'd3, 1'b1, pss_pkg::ST_NOT_FOUND},
		'{pss_pkg::OP_REMOVE, 8'd2,   16'd0,    4'd8, 1'b1, pss_pkg::ST_OK},
		'{pss_pkg::OP_NONE,   8'hFF,  16'hFFFF, 4'hF, 1'b1, pss_pkg::ST_OK},
		'{pss_pkg::OP_STOP,   8'd0,   16'd0,    4'd0, 1'b1, pss_pkg::ST_OK},
		'{pss_pkg::OP_LIST,   8'd0,   16'd0,    4'd0, 1'b1, pss_pkg::ST_OK}
	};

	function automatic pss_pkg::req_t random_op();
		pss_pkg::req_t r;
		int k;
		r.sid = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
		k = $urandom_range(0, 3);
		r.period = (k == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
		r.command_index = ($urandom_range(0, 3) == 0) ? 4'($urandom) :
			(($urandom_range(0, 1) == 0) ? 4'd3 : 4'd8);
		k = $urandom_range(0, 99);
		if (k < 30) r.command = pss_pkg::OP_ADD;
		else if (k < 40) r.command = pss_pkg::OP_REMOVE;
		else if (k < 47) r.command = pss_pkg::OP_QUERY;
		else if (k < 52) r.command = pss_pkg::OP_LIST;
		else if (k < 75) r.command = pss_pkg::OP_TICK;
		else if (k < 97) r.command = pss_pkg::OP_POLL;
		else if (k < 99) r.command = pss_pkg::OP_STOP;
		else r.command = pss_pkg::OP_NONE;
		return r;
	endfunction

	initial begin
		pss_pkg::req_t r;
		pss_pkg::rsp_t x;
		int gap;
		streamable = 16'h0108;
		cmd_count = 5'd9;
		for (int i = 0; i < DEPTH; i++) begin
			t_id[i] = 0; t_cmd[i] = 0; t_per[i] = 0; t_cd[i] = 0; t_pend[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[n]) begin
			r.command = directed[n].op;
			r.sid = directed[n].id;
			r.period = directed[n].per;
			r.command_index = directed[n].ci;
			send_op(r, 0);
			if (directed[n].chk) begin
				x = expected_rsp[$];
				if (x.status != directed[n].st || x.active_mask != 0 || x.fired != 0) begin
					$error("directed row %0d status exp %0d got %0d", n,
						directed[n].st, x.status);
					errors++;
				end
			end
		end
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_reg(pss_pkg::CFG_STREAMABLE, 16'hFFFF);
					write_reg(pss_pkg::CFG_COUNT, 16'd16);
				end
				1: begin
					write_reg(pss_pkg::CFG_STREAMABLE, 16'h0000);
					write_reg(pss_pkg::CFG_COUNT, 16'd1);
				end
				2: begin
					write_reg(pss_pkg::CFG_STREAMABLE, 16'($urandom) | 16'h0108);
					write_reg(pss_pkg::CFG_COUNT, 16'($urandom_range(1, 16)));
				end
				3: begin
					write_reg(pss_pkg::CFG_STREAMABLE, 16'h0108);
					write_reg(pss_pkg::CFG_COUNT, 16'd0);
				end
				default: begin
					write_reg(pss_pkg::CFG_STREAMABLE, 16'hFFFF);
					write_reg(pss_pkg::CFG_COUNT, 16'd31);
				end
			endcase
			gap = 0;
			for (int n = 0; n < N_RANDOM / 5; n++) begin
				if (phase < 4 && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 10);
				else gap = 0;
				if (n == 100) drain();
				send_op(random_op(), gap);
			end
			drain();
		end

		if (errors == 0) $display("testbench passed");
		else $display("testbench failed");
		$finish;
	end
endmodule
